// ===== sv/plc_pkg.sv =====
// plc_pkg: shared types and constants of the positional list
// command, status and position class codes, cell control struct
// no dependencies
package plc_pkg;

  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned ELEM_WIDTH_DEF = 32;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned POS_W          = 32;
  localparam int unsigned CODE_W         = 2;

  typedef enum logic [CODE_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [CODE_W-1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [CODE_W-1:0] {
    CLS_BEFORE = 2'd0,
    CLS_VALID  = 2'd1,
    CLS_PAST   = 2'd2
  } class_e;

  // shift controls broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_op_t;

endpackage

// ===== sv/plc_if.sv =====
// plc_in_if / plc_out_if: valid-ready channels of the positional list
// depends on plc_pkg for field widths
interface plc_in_if;
  logic                                valid;
  logic                                ready;
  logic [plc_pkg::CODE_W-1:0]          cmd;
  logic signed [plc_pkg::POS_W-1:0]    position;
  logic [plc_pkg::DATA_W-1:0]          value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface plc_out_if #(
  parameter int unsigned CNT_W = 7
);
  logic                       valid;
  logic                       ready;
  logic [plc_pkg::DATA_W-1:0] read_value;
  logic [plc_pkg::CODE_W-1:0] status;
  logic [plc_pkg::CODE_W-1:0] position_class;
  logic [CNT_W-1:0]           count;

  modport source (output valid, read_value, status, position_class, count, input ready);
  modport sink   (input valid, read_value, status, position_class, count, output ready);
endinterface

// ===== sv/positional_list_insert_delete_top.sv =====
// positional_list_insert_delete_top: positional list built as a row of cells
// depends on plc_pkg, plc_if, plc_ctrl, plc_cell
//
// Usage:
//   in_chan carries a command word (cmd, position, value); out_chan returns one
//   result word per command (read_value, status, position_class, count).
//   Both channels move a word when valid and ready are high at a clock edge.
//   Each stored entry sits in its own cell; an insert moves every cell past
//   the target one place toward the rear, a delete one place toward the front,
//   all cells in the same cycle. A read selects the cell at the target.
//   A word accepted into the command register is executed once the output
//   register is free or being taken, and its result is shown from then on.
//   A new word is taken only once the command register is free, so no new word
//   enters while one waits there behind the single output register.
//   If the receiver stalls, the result holds in the output register and the
//   next command waits in the command register until the result is taken.
//   Reset clears the entry count and both valid flags; entry contents are
//   not cleared, only positions below the count are ever read.
module positional_list_insert_delete_top #(
  parameter int unsigned DEPTH      = plc_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = plc_pkg::ELEM_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  plc_in_if.sink      in_chan,
  plc_out_if.source   out_chan
);

  localparam int unsigned AW = $clog2(DEPTH);

  plc_pkg::cell_op_t      op;
  logic [AW-1:0]          idx;
  logic [ELEM_WIDTH-1:0]  value;
  logic [ELEM_WIDTH-1:0]  rd_data;
  logic [ELEM_WIDTH-1:0]  cell_data [DEPTH];
  logic [ELEM_WIDTH-1:0]  cell_rd   [DEPTH];

  plc_ctrl #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .op_o      (op),
    .idx_o     (idx),
    .value_o   (value),
    .rd_data_i (rd_data)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    // last cell keeps its word on delete, it is past the new count anyway
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    plc_cell #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .idx_i   (idx),
      .value_i (value),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // only the addressed cell drives a nonzero read word
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

endmodule

// ===== sv/plc_cell.sv =====
// plc_cell: one entry of the positional list
// takes its left neighbor on insert, its right neighbor on delete
// depends on plc_pkg
module plc_cell #(
  parameter int unsigned DEPTH      = plc_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = plc_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned INDEX      = 0
) (
  input  logic                      clk_i,
  input  plc_pkg::cell_op_t         op_i,
  input  logic [$clog2(DEPTH)-1:0]  idx_i,
  input  logic [ELEM_WIDTH-1:0]     value_i,
  input  logic [ELEM_WIDTH-1:0]     left_i,
  input  logic [ELEM_WIDTH-1:0]     right_i,
  output logic [ELEM_WIDTH-1:0]     data_o,
  output logic [ELEM_WIDTH-1:0]     rd_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] MY_IDX = AW'(INDEX);

  logic [ELEM_WIDTH-1:0] data_q;
  logic                  hit;
  logic                  above;

  assign hit   = (idx_i == MY_IDX);
  assign above = (MY_IDX > idx_i);

  always_ff @(posedge clk_i) begin
    if (op_i.ins) begin
      if (hit) begin
        data_q <= value_i;
      end else if (above) begin
        data_q <= left_i;
      end
    end else if (op_i.del && (hit || above)) begin
      data_q <= right_i;
    end
  end

  assign data_o = data_q;
  assign rd_o   = hit ? data_q : '0;

endmodule

// ===== sv/plc_ctrl.sv =====
// plc_ctrl: command register, position classing, entry count and result word
// drives the shift controls of the cell row
// depends on plc_pkg and plc_if
module plc_ctrl #(
  parameter int unsigned DEPTH      = plc_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = plc_pkg::ELEM_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  plc_in_if.sink                    in_chan,
  plc_out_if.source                 out_chan,
  output plc_pkg::cell_op_t         op_o,
  output logic [$clog2(DEPTH)-1:0]  idx_o,
  output logic [ELEM_WIDTH-1:0]     value_o,
  input  logic [ELEM_WIDTH-1:0]     rd_data_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam int unsigned DW = plc_pkg::DATA_W;
  localparam int unsigned PW = plc_pkg::POS_W;

  logic                       req_valid_q;
  logic [plc_pkg::CODE_W-1:0] cmd_q;
  logic [PW-1:0]              pos_q;
  logic [ELEM_WIDTH-1:0]      val_q;
  logic [CW-1:0]              count_q, count_d;

  logic                       out_valid_q;
  logic [DW-1:0]              rv_q, rv_d;
  plc_pkg::status_e           st_q, st_d;
  plc_pkg::class_e            cls_q, cls_d;

  logic                       fire;
  logic [ELEM_WIDTH-1:0]      in_val;
  logic [DW-1:0]              rd_wide;

  // fit the value word to the entry width and back
  if (ELEM_WIDTH >= DW) begin : g_wide
    assign in_val  = ELEM_WIDTH'(in_chan.value);
    assign rd_wide = rd_data_i[DW-1:0];
  end else begin : g_narrow
    assign in_val  = in_chan.value[ELEM_WIDTH-1:0];
    assign rd_wide = DW'(rd_data_i);
  end

  assign in_chan.ready = !req_valid_q;
  assign fire = req_valid_q && (!out_valid_q || out_chan.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      req_valid_q <= 1'b1;
    end else if (fire) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.valid && in_chan.ready) begin
      cmd_q <= in_chan.cmd;
      pos_q <= in_chan.position;
      val_q <= in_val;
    end
  end

  // classify against the count held before the command
  always_comb begin
    cls_d   = plc_pkg::CLS_VALID;
    st_d    = plc_pkg::ST_INVALID;
    rv_d    = '0;
    count_d = count_q;
    op_o    = '0;
    idx_o   = pos_q[AW-1:0];
    if (pos_q[PW-1]) begin
      cls_d = plc_pkg::CLS_BEFORE;
    end else if (pos_q >= PW'(count_q)) begin
      cls_d = plc_pkg::CLS_PAST;
      idx_o = count_q[AW-1:0];
    end
    unique case (cmd_q)
      plc_pkg::CMD_INSERT: begin
        if (cls_d == plc_pkg::CLS_BEFORE) begin
          st_d = plc_pkg::ST_INVALID;
        end else if (count_q == FULL_CNT) begin
          st_d = plc_pkg::ST_FULL;
        end else begin
          st_d    = plc_pkg::ST_DONE;
          op_o.ins = fire;
          count_d = count_q + CW'(1);
        end
      end
      plc_pkg::CMD_DELETE: begin
        if (cls_d == plc_pkg::CLS_VALID) begin
          st_d    = plc_pkg::ST_DONE;
          op_o.del = fire;
          count_d = count_q - CW'(1);
        end
      end
      plc_pkg::CMD_READ: begin
        if (cls_d == plc_pkg::CLS_VALID) begin
          st_d = plc_pkg::ST_DONE;
          rv_d = rd_wide;
        end
      end
      default: st_d = plc_pkg::ST_INVALID;
    endcase
  end

  assign value_o = val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rv_q  <= rv_d;
      st_q  <= st_d;
      cls_q <= cls_d;
    end
  end

  assign out_chan.valid          = out_valid_q;
  assign out_chan.read_value     = rv_q;
  assign out_chan.status         = st_q;
  assign out_chan.position_class = cls_q;
  assign out_chan.count          = count_q;

endmodule

// ===== sv/plc_checker.sv =====
// plc_checker: port-level checks of the positional list, bound to the top level
// depends on plc_pkg
module plc_checker #(
  parameter int unsigned DEPTH = plc_pkg::DEPTH_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [plc_pkg::DATA_W-1:0]   read_value_i,
  input logic [plc_pkg::CODE_W-1:0]   status_i,
  input logic [plc_pkg::CODE_W-1:0]   position_class_i,
  input logic [$clog2(DEPTH+1)-1:0]   count_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(count_i))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_i <= CW'(DEPTH))
    else $error("count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == plc_pkg::ST_FULL |-> count_i == CW'(DEPTH))
    else $error("full refusal with room left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && position_class_i == plc_pkg::CLS_BEFORE |-> status_i == plc_pkg::ST_INVALID)
    else $error("negative position not ignored");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && read_value_i != '0 |->
      status_i == plc_pkg::ST_DONE && position_class_i == plc_pkg::CLS_VALID)
    else $error("read word without a valid read");

endmodule

bind positional_list_insert_delete_top plc_checker #(
  .DEPTH (DEPTH)
) u_plc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_chan.valid),
  .out_ready_i      (out_chan.ready),
  .read_value_i     (out_chan.read_value),
  .status_i         (out_chan.status),
  .position_class_i (out_chan.position_class),
  .count_i          (out_chan.count)
);
